// ----- design/bdyuv_pkg.sv -----
// Shared types, constants and the Bayer site lookup for the demosaic/YUV block.
// No dependencies; used by bayer_demosaic_to_yuv444.
`timescale 1ns / 1ps
`default_nettype none

package bdyuv_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BAYER_ORDER  = 2'd2;

    localparam int unsigned DEF_MAX_WIDTH = 4096;

    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [15:0] RST_FRAME_HEIGHT = 16'd480;
    localparam logic [1:0]  RST_BAYER_ORDER  = 2'd0;

    // filter layouts
    localparam logic [1:0] ORDER_GRBG = 2'd0;
    localparam logic [1:0] ORDER_RGGB = 2'd1;
    localparam logic [1:0] ORDER_BGGR = 2'd2;
    localparam logic [1:0] ORDER_GBRG = 2'd3;

    // BT.601 studio-range coefficients
    localparam logic [7:0] COEF_Y_R  = 8'd66;
    localparam logic [7:0] COEF_Y_G  = 8'd129;
    localparam logic [7:0] COEF_Y_B  = 8'd25;
    localparam logic [7:0] COEF_CB_R = 8'd38;
    localparam logic [7:0] COEF_CB_G = 8'd74;
    localparam logic [7:0] COEF_CB_B = 8'd112;
    localparam logic [7:0] COEF_CR_R = 8'd112;
    localparam logic [7:0] COEF_CR_G = 8'd94;
    localparam logic [7:0] COEF_CR_B = 8'd18;
    localparam logic [7:0] ROUND_TERM    = 8'd128;
    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

    typedef enum logic [1:0] {
        SITE_RED     = 2'd0,
        SITE_GREEN_R = 2'd1,
        SITE_GREEN_B = 2'd2,
        SITE_BLUE    = 2'd3
    } site_kind_t;

    typedef struct packed {
        logic [7:0] raw_pixel;
        logic       frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [11:0] out_col;
        logic [15:0] out_row;
        logic [7:0]  luma;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
    } pix_out_t;

    // color of the filter at a site, from the row and column parity
    function automatic site_kind_t site_kind(input logic [1:0] order,
                                             input logic row_odd,
                                             input logic col_odd);
        logic [1:0] code;
        begin
            unique case (order)
                ORDER_GRBG: code = {row_odd, ~col_odd};
                ORDER_RGGB: code = {row_odd, col_odd};
                ORDER_BGGR: code = {~row_odd, ~col_odd};
                ORDER_GBRG: code = {~row_odd, col_odd};
                default:    code = {row_odd, col_odd};
            endcase
            return site_kind_t'(code);
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/bdyuv_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdyuv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write on an address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/bayer_demosaic_to_yuv444.sv -----
// Bayer bilinear demosaic with BT.601 YCbCr 4:4:4 output, top level.
// Depends on bdyuv_pkg and bdyuv_ram (two line stores).
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes raw 8-bit samples in
//   raster order; frame_start on an item forces it to position (0,0).
//   Every accepted item yields exactly one result item on the output channel
//   (out_valid / out_stall / out_item) for the pixel one column and one line
//   behind it, wrapping at the frame edges. Border pixels give 16/128/128.
//   Throughput is one item per cycle while in_stall is low. A result passes
//   through the line store read, interpolation, multiply, then the output
//   register before it is valid. Line stores are read at an item's column on
//   acceptance and written there in stage 1; a same-address hit is forwarded.
//   A stalled output holds its item; one more item lands in a skid register,
//   and only then does in_stall rise (it is registered, no stall path
//   crosses the block).
//   Reset clears counters, window and pipeline; configuration returns to
//   640x480 GRBG. Line stores are not cleared and need no clearing pass.
//   Configuration (cfg_write / cfg_index / cfg_data) is written while idle.
`timescale 1ns / 1ps
`default_nettype none

module bayer_demosaic_to_yuv444 #(
    parameter int MAX_WIDTH = bdyuv_pkg::DEF_MAX_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bdyuv_pkg::pix_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bdyuv_pkg::pix_out_t    out_item
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = (XW + 1 > 13) ? XW + 1 : 13;

    // configuration
    logic [12:0] frame_width_reg;
    logic [15:0] frame_height_reg;
    logic [1:0]  bayer_order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bdyuv_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= bdyuv_pkg::RST_FRAME_HEIGHT;
            bayer_order_reg  <= bdyuv_pkg::RST_BAYER_ORDER;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bdyuv_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                bdyuv_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                bdyuv_pkg::CFG_BAYER_ORDER:  bayer_order_reg  <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    logic                skid_valid_reg;
    logic                out_valid_reg;
    bdyuv_pkg::pix_out_t out_item_reg;
    bdyuv_pkg::pix_out_t skid_item_reg;
    logic                en;
    logic                accept;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && en;

    // raster position
    logic [XW-1:0] column_count_reg;
    logic [15:0]   row_count_reg;
    logic [WW-1:0] fw_ext, w_eff, x_raw, x_pos, x_inc, x_wrap, cx;
    logic [15:0]   h_eff, y_raw, y_pos, y_inc, y_wrap, cy;
    logic          inner;
    bdyuv_pkg::site_kind_t kind;

    always_comb
    begin
        fw_ext = WW'(frame_width_reg);
        if (fw_ext == '0)
            w_eff = WW'(1);
        else if (fw_ext > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        h_eff = (frame_height_reg == 16'd0) ? 16'd1 : frame_height_reg;

        x_raw = in_item.frame_start ? '0 : WW'(column_count_reg);
        y_raw = in_item.frame_start ? '0 : row_count_reg;
        x_pos = (x_raw >= w_eff) ? '0 : x_raw;
        y_pos = (y_raw >= h_eff) ? '0 : y_raw;

        cx = (x_pos == '0) ? w_eff - WW'(1) : x_pos - WW'(1);
        cy = (y_pos == '0) ? h_eff - 16'd1 : y_pos - 16'd1;
        inner = (x_pos >= WW'(2)) && (y_pos >= 16'd2);
        kind = bdyuv_pkg::site_kind(bayer_order_reg, cy[0], cx[0]);

        x_inc  = x_pos + WW'(1);
        y_inc  = y_pos + 16'd1;
        x_wrap = x_inc;
        y_wrap = y_pos;
        if (x_inc >= w_eff)
        begin
            x_wrap = '0;
            y_wrap = (y_inc >= h_eff) ? 16'd0 : y_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (accept)
        begin
            column_count_reg <= x_wrap[XW-1:0];
            row_count_reg    <= y_wrap;
        end
    end

    // stage 1: line store data, window, interpolation
    logic                  s1_valid_reg;
    logic [XW-1:0]         s1_addr_reg;
    logic [7:0]            s1_pixel_reg;
    logic                  s1_inner_reg;
    bdyuv_pkg::site_kind_t s1_kind_reg;
    logic [11:0]           s1_col_reg;
    logic [15:0]           s1_row_reg;
    logic                  fwd_hit_reg;
    logic [7:0]            fwd_older_reg;
    logic [7:0]            fwd_newer_reg;
    logic [7:0]            older_q, newer_q, older_rd, newer_rd;
    logic [7:0]            win_reg [6];
    logic                  store_wr;

    assign older_rd = fwd_hit_reg ? fwd_older_reg : older_q;
    assign newer_rd = fwd_hit_reg ? fwd_newer_reg : newer_q;
    assign store_wr = en && s1_valid_reg;

    bdyuv_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_store_older (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (newer_rd),
        .rd_en   (en),
        .rd_addr (x_pos[XW-1:0]),
        .rd_data (older_q)
    );

    bdyuv_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_store_newer (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (en),
        .rd_addr (x_pos[XW-1:0]),
        .rd_data (newer_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            // write of the item in stage 1 lands this edge: RAM read misses it
            fwd_hit_reg  <= accept && s1_valid_reg && (s1_addr_reg == x_pos[XW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= x_pos[XW-1:0];
            s1_pixel_reg  <= in_item.raw_pixel;
            s1_inner_reg  <= inner;
            s1_kind_reg   <= kind;
            s1_col_reg    <= cx[11:0];
            s1_row_reg    <= cy;
            fwd_older_reg <= newer_rd;
            fwd_newer_reg <= s1_pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (store_wr)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= older_rd;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= newer_rd;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pixel_reg;
        end
    end

    logic [8:0] hs, vs;
    logic [9:0] cross_sum, diag;
    logic [7:0] r_val, g_val, b_val;

    always_comb
    begin
        hs        = 9'(win_reg[2]) + 9'(newer_rd);
        vs        = 9'(win_reg[1]) + 9'(win_reg[5]);
        cross_sum = 10'(hs) + 10'(vs);
        diag  = 10'(win_reg[0]) + 10'(older_rd) + 10'(win_reg[4]) + 10'(s1_pixel_reg);
        unique case (s1_kind_reg)
            bdyuv_pkg::SITE_RED:
            begin
                r_val = win_reg[3];
                g_val = cross_sum[9:2];
                b_val = diag[9:2];
            end
            bdyuv_pkg::SITE_GREEN_R:
            begin
                r_val = hs[8:1];
                g_val = win_reg[3];
                b_val = vs[8:1];
            end
            bdyuv_pkg::SITE_GREEN_B:
            begin
                r_val = vs[8:1];
                g_val = win_reg[3];
                b_val = hs[8:1];
            end
            default:
            begin
                r_val = diag[9:2];
                g_val = cross_sum[9:2];
                b_val = win_reg[3];
            end
        endcase
        if (!s1_inner_reg)
        begin
            r_val = 8'd0;
            g_val = 8'd0;
            b_val = 8'd0;
        end
    end

    // stage 2: RGB
    logic        s2_valid_reg;
    logic [7:0]  s2_r_reg, s2_g_reg, s2_b_reg;
    logic [11:0] s2_col_reg;
    logic [15:0] s2_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            s2_r_reg   <= r_val;
            s2_g_reg   <= g_val;
            s2_b_reg   <= b_val;
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
    end

    // stage 3: coefficient products
    logic        s3_valid_reg;
    logic [15:0] py_r_reg, py_g_reg, py_b_reg;
    logic [15:0] pcb_r_reg, pcb_g_reg, pcb_b_reg;
    logic [15:0] pcr_r_reg, pcr_g_reg, pcr_b_reg;
    logic [11:0] s3_col_reg;
    logic [15:0] s3_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg)
        begin
            py_r_reg   <= 16'(s2_r_reg) * 16'(bdyuv_pkg::COEF_Y_R);
            py_g_reg   <= 16'(s2_g_reg) * 16'(bdyuv_pkg::COEF_Y_G);
            py_b_reg   <= 16'(s2_b_reg) * 16'(bdyuv_pkg::COEF_Y_B);
            pcb_r_reg  <= 16'(s2_r_reg) * 16'(bdyuv_pkg::COEF_CB_R);
            pcb_g_reg  <= 16'(s2_g_reg) * 16'(bdyuv_pkg::COEF_CB_G);
            pcb_b_reg  <= 16'(s2_b_reg) * 16'(bdyuv_pkg::COEF_CB_B);
            pcr_r_reg  <= 16'(s2_r_reg) * 16'(bdyuv_pkg::COEF_CR_R);
            pcr_g_reg  <= 16'(s2_g_reg) * 16'(bdyuv_pkg::COEF_CR_G);
            pcr_b_reg  <= 16'(s2_b_reg) * 16'(bdyuv_pkg::COEF_CR_B);
            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
        end
    end

    // sums, flooring shift, offsets
    logic signed [17:0] y_sum, cb_sum, cr_sum;
    logic signed [17:0] y_sh, cb_sh, cr_sh;
    bdyuv_pkg::pix_out_t res;

    always_comb
    begin
        y_sum  = 18'(py_r_reg) + 18'(py_g_reg) + 18'(py_b_reg)
                 + 18'(bdyuv_pkg::ROUND_TERM);
        cb_sum = 18'(pcb_b_reg) - 18'(pcb_r_reg) - 18'(pcb_g_reg)
                 + 18'(bdyuv_pkg::ROUND_TERM);
        cr_sum = 18'(pcr_r_reg) - 18'(pcr_g_reg) - 18'(pcr_b_reg)
                 + 18'(bdyuv_pkg::ROUND_TERM);
        y_sh  = y_sum >>> 8;
        cb_sh = cb_sum >>> 8;
        cr_sh = cr_sum >>> 8;
        res.out_col     = s3_col_reg;
        res.out_row     = s3_row_reg;
        res.luma        = y_sh[7:0] + bdyuv_pkg::LUMA_OFFSET;
        res.chroma_blue = cb_sh[7:0] + bdyuv_pkg::CHROMA_OFFSET;
        res.chroma_red  = cr_sh[7:0] + bdyuv_pkg::CHROMA_OFFSET;
    end

    // output register and skid
    logic out_take;
    logic push;

    assign out_take = out_valid_reg && !out_stall;
    assign push     = en && s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_take)
                    skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                if (out_valid_reg && !out_take)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_take)
                out_item_reg <= skid_item_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
                skid_item_reg <= res;
            else
                out_item_reg <= res;
        end
        else
        begin
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && s3_valid_reg))
        else $error("skid filled without a stalled output");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output item appeared with no item in the last stage");

    a_fwd_has_writer: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("line store forward without an item in stage 1");

endmodule

`default_nettype wire

// ----- tb/bayer_demosaic_to_yuv444_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bayer_demosaic_to_yuv444: raw Bayer stream in, YCbCr 4:4:4 out.
// Needs bdyuv_pkg and the design files; a scoreboard class predicts every result item.

module bayer_demosaic_to_yuv444_tb;

    class demosaic_scoreboard;
        logic [12:0] width_reg;
        logic [15:0] height_reg;
        logic [1:0]  order_reg;
        logic [7:0]  older_line [bdyuv_pkg::DEF_MAX_WIDTH];
        logic [7:0]  newer_line [bdyuv_pkg::DEF_MAX_WIDTH];
        logic [7:0]  win [6];
        int unsigned col_cnt;
        int unsigned row_cnt;
        bdyuv_pkg::pix_out_t pending_yuv [$];
        int unsigned fail_count;

        function new();
            width_reg  = bdyuv_pkg::RST_FRAME_WIDTH;
            height_reg = bdyuv_pkg::RST_FRAME_HEIGHT;
            order_reg  = bdyuv_pkg::RST_BAYER_ORDER;
            foreach (older_line[i])
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            fail_count = 0;
        endfunction

        function int unsigned active_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > bdyuv_pkg::DEF_MAX_WIDTH)
                return bdyuv_pkg::DEF_MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned pending();
            return pending_yuv.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                bdyuv_pkg::CFG_FRAME_WIDTH:  width_reg = data[12:0];
                bdyuv_pkg::CFG_FRAME_HEIGHT: height_reg = data;
                bdyuv_pkg::CFG_BAYER_ORDER:  order_reg = data[1:0];
                default: ;
            endcase
        endfunction

        // filter color at a pixel: flip the parities against where red sits
        function bdyuv_pkg::site_kind_t filter_color(int unsigned cx, int unsigned cy);
            logic red_row;
            logic red_col;
            logic rp;
            logic cp;
            case (order_reg)
                bdyuv_pkg::ORDER_GRBG: begin red_row = 1'b0; red_col = 1'b1; end
                bdyuv_pkg::ORDER_RGGB: begin red_row = 1'b0; red_col = 1'b0; end
                bdyuv_pkg::ORDER_BGGR: begin red_row = 1'b1; red_col = 1'b1; end
                default:               begin red_row = 1'b1; red_col = 1'b0; end
            endcase
            rp = cy[0] ^ red_row;
            cp = cx[0] ^ red_col;
            if (!rp && !cp)
                return bdyuv_pkg::SITE_RED;
            if (!rp)
                return bdyuv_pkg::SITE_GREEN_R;
            if (!cp)
                return bdyuv_pkg::SITE_GREEN_B;
            return bdyuv_pkg::SITE_BLUE;
        endfunction

        function void take_raw_sample(bdyuv_pkg::pix_in_t it);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            int unsigned cx;
            int unsigned cy;
            int c;
            int hs;
            int vs;
            int cross_sum;
            int diag;
            int r;
            int g;
            int b;
            int yv;
            int cbv;
            int crv;
            logic [7:0] up_right;
            logic [7:0] mid_right;
            bdyuv_pkg::pix_out_t yuv;

            w = active_width();
            h = (height_reg == 0) ? 1 : height_reg;
            x = col_cnt;
            y = row_cnt;
            if (it.frame_start)
            begin
                x = 0;
                y = 0;
            end
            if (x >= w)
                x = 0;
            if (y >= h)
                y = 0;

            up_right  = older_line[x];
            mid_right = newer_line[x];
            cx = (x == 0) ? w - 1 : x - 1;
            cy = (y == 0) ? h - 1 : y - 1;

            r = 0;
            g = 0;
            b = 0;
            if (x >= 2 && y >= 2)
            begin
                c         = int'(win[3]);
                hs        = int'(win[2]) + int'(mid_right);
                vs        = int'(win[1]) + int'(win[5]);
                cross_sum = hs + vs;
                diag      = int'(win[0]) + int'(up_right) + int'(win[4]) + int'(it.raw_pixel);
                case (filter_color(cx, cy))
                    bdyuv_pkg::SITE_RED:
                    begin
                        r = c;        g = cross_sum / 4; b = diag / 4;
                    end
                    bdyuv_pkg::SITE_GREEN_R:
                    begin
                        r = hs / 2;   g = c;             b = vs / 2;
                    end
                    bdyuv_pkg::SITE_GREEN_B:
                    begin
                        r = vs / 2;   g = c;             b = hs / 2;
                    end
                    default:
                    begin
                        r = diag / 4; g = cross_sum / 4; b = c;
                    end
                endcase
            end

            win[0] = win[1];
            win[1] = up_right;
            win[2] = win[3];
            win[3] = mid_right;
            win[4] = win[5];
            win[5] = it.raw_pixel;
            older_line[x] = mid_right;
            newer_line[x] = it.raw_pixel;

            x++;
            if (x >= w)
            begin
                x = 0;
                y++;
                if (y >= h)
                    y = 0;
            end
            col_cnt = x;
            row_cnt = y;

            // arithmetic shift floors the negative chroma sums
            yv  = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
            cbv = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
            crv = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;

            yuv.out_col     = cx[11:0];
            yuv.out_row     = cy[15:0];
            yuv.luma        = yv[7:0];
            yuv.chroma_blue = cbv[7:0];
            yuv.chroma_red  = crv[7:0];
            pending_yuv.push_back(yuv);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_yuv(bdyuv_pkg::pix_out_t got);
            bdyuv_pkg::pix_out_t want;
            if (pending_yuv.size() == 0)
            begin
                $error("result item with nothing pending: col %0d row %0d",
                       got.out_col, got.out_row);
                fail_count++;
                return;
            end
            want = pending_yuv.pop_front();
            compare_field("out_col", 16'(want.out_col), 16'(got.out_col));
            compare_field("out_row", want.out_row, got.out_row);
            compare_field("luma", 16'(want.luma), 16'(got.luma));
            compare_field("chroma_blue", 16'(want.chroma_blue), 16'(got.chroma_blue));
            compare_field("chroma_red", 16'(want.chroma_red), 16'(got.chroma_red));
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_write = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bdyuv_pkg::pix_in_t  in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bdyuv_pkg::pix_out_t out_item;

    demosaic_scoreboard sb;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          restart_due = 1'b0;
    int unsigned total_items;
    int unsigned sent;

    bayer_demosaic_to_yuv444 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.take_raw_sample(in_item);
        if (rst_n && out_valid && !out_stall)
            sb.check_yuv(out_item);
    end

    task automatic send_item(input logic [7:0] raw, input logic start);
        bdyuv_pkg::pix_in_t it;
        it.raw_pixel   = raw;
        it.frame_start = start | restart_due;
        restart_due    = 1'b0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result item
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    // a wider line would read store entries never written, so restart the frame
    task automatic program_regs(input logic [2:0] sel, input logic [15:0] w_data,
                                input logic [15:0] h_data, input logic [15:0] o_data);
        logic [1:0]  idx;
        logic [15:0] data;
        int unsigned old_w;
        old_w = sb.active_width();
        for (int i = 0; i < 3; i++)
        begin
            idx = 2'(i);
            if (sel[i])
            begin
                case (idx)
                    bdyuv_pkg::CFG_FRAME_WIDTH:  data = w_data;
                    bdyuv_pkg::CFG_FRAME_HEIGHT: data = h_data;
                    default:                     data = o_data;
                endcase
                cfg_write <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= data;
                @(posedge clk);
                sb.write_reg(idx, data);
            end
        end
        cfg_write <= 1'b0;
        if (sb.active_width() > old_w)
            restart_due = 1'b1;
    endtask

    function automatic logic [7:0] pick_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 8'd0;
        if (pick < 16)
            return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic directed_items();
        // 4x4 frame: every filter color gets an interior pixel
        program_regs(3'b111, 16'd4, 16'd4, 16'(bdyuv_pkg::ORDER_GRBG));
        for (int i = 0; i < 16; i++)
            send_item((((i ^ (i >> 2) ^ (i >> 3)) & 1) != 0) ? 8'd255 : 8'd0, i == 0);
        for (int i = 0; i < 6; i++)
            send_item(8'(i * 51), 1'b0);
        settle();
        // column counter now past the narrower line; upper data bits are ignored
        program_regs(3'b001, {3'b111, 13'd2}, 16'd0, 16'd0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        settle();
        // zero width and height clamp to one pixel
        program_regs(3'b011, 16'd0, 16'd0, 16'd0);
        send_item(8'd170, 1'b0);
        settle();
        // width above the line store size clamps to the maximum
        program_regs(3'b011, 16'hFFFF, 16'hFFFF, 16'd0);
        send_item(8'd255, 1'b1);
        send_item(8'd85, 1'b0);
        settle();
    endtask

    task automatic random_phase(output int unsigned n);
        logic [2:0]  sel;
        logic [15:0] wd;
        logic [15:0] hd;
        logic [15:0] od;
        int unsigned pick;
        logic        start;

        sel  = ($urandom_range(99) < 60) ? 3'b111 : 3'($urandom_range(1, 7));
        pick = $urandom_range(99);
        if (pick < 80)
            wd = 16'($urandom_range(3, 12));
        else if (pick < 88)
            wd = 16'($urandom_range(0, 2));
        else if (pick < 94)
            wd = 16'($urandom_range(13, 40));
        else
            wd = 16'($urandom_range(4096, 8191));
        wd[15:13] = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 75)
            hd = 16'($urandom_range(3, 8));
        else if (pick < 85)
            hd = 16'($urandom_range(0, 2));
        else if (pick < 93)
            hd = 16'($urandom_range(9, 65535));
        else
            hd = 16'($urandom_range(65534, 65535));
        od = 16'($urandom);
        program_regs(sel, wd, hd, od);

        n = (sb.active_width() > 40) ? 12 : $urandom_range(15, 90);
        for (int k = 0; k < n; k++)
        begin
            start = (k == 0 && $urandom_range(99) < 70) || ($urandom_range(99) < 2);
            send_item(pick_pixel(), start);
            if ($urandom_range(199) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 34;
        rx_idle_pct = 70;
        directed_items();

        total_items = 0;
        while (total_items < 1600)
        begin
            if (total_items >= 1066)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (total_items >= 533)
            begin
                tx_idle_pct = 70;
                rx_idle_pct = 34;
            end
            random_phase(sent);
            total_items += sent;
        end

        repeat (10) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- bayer_demosaic_to_yuv444.f -----
design/bdyuv_pkg.sv
design/bdyuv_ram.sv
design/bayer_demosaic_to_yuv444.sv
tb/bayer_demosaic_to_yuv444_tb.sv
